[src/skof_pkg.sv]
// ----------------------------------------------------------------------------
// skof_pkg
// Shared types and constants of the scalar Kalman offset filter.
// ----------------------------------------------------------------------------
package skof_pkg;

	// Gain format: signed Q16.48
	localparam int unsigned GAIN_FRAC_BITS = 48;
	localparam logic [63:0] GAIN_ONE = 64'd1 << GAIN_FRAC_BITS;
	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

	// Divider runs one quotient bit per cycle over a 64 + 48 bit dividend
	localparam int unsigned DIV_STEPS = 64 + GAIN_FRAC_BITS;
	localparam int unsigned DIV_CNT_BITS = $clog2(DIV_STEPS);

	// Request kinds
	localparam logic [1:0] REQ_SAMPLE  = 2'd0;
	localparam logic [1:0] REQ_CORR    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PROCESS_NOISE = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MEAS_NOISE    = 1'b1;

	// Request to the shared multiplier: (a * b) >> 48, saturated
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	// Request to the shared divider: floor(num * 2^48 / den), saturated
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
		logic        lim_one;
	} div_req_t;

endpackage

[src/skof_mul.sv]
// ----------------------------------------------------------------------------
// skof_mul
// Multi-cycle 64x64 multiplier built on one 32x32 product, returning the
// product shifted right by the gain fraction bits, saturated at all ones.
// ----------------------------------------------------------------------------
module skof_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  skof_pkg::mul_req_t req,
	output logic              done,
	output logic [63:0]       result
);
	import skof_pkg::*;

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_q;
	logic [1:0]   pp_sh_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;

	logic [31:0]  op_a, op_b;
	logic [1:0]   op_sh;
	logic [127:0] pp_ext;

	// Pick the partial product for this step
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				op_a = a_q[31:0];  op_b = b_q[31:0];  op_sh = 2'd0;
			end
			2'd1: begin
				op_a = a_q[31:0];  op_b = b_q[63:32]; op_sh = 2'd1;
			end
			2'd2: begin
				op_a = a_q[63:32]; op_b = b_q[31:0];  op_sh = 2'd1;
			end
			default: begin
				op_a = a_q[63:32]; op_b = b_q[63:32]; op_sh = 2'd2;
			end
		endcase
	end

	// Align the registered partial product
	always_comb begin
		case (pp_sh_q)
			2'd0:    pp_ext = {64'd0, pp_q};
			2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
			default: pp_ext = {pp_q, 64'd0};
		endcase
	end

	// Sequence the four partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Multiply and accumulate
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_q    <= op_a * op_b;
				pp_sh_q <= op_sh;
			end
			if (cnt_q != 3'd0)
				acc_q <= acc_q + pp_ext;
		end
	end

	assign done   = done_q;
	assign result = (|acc_q[127:64+GAIN_FRAC_BITS]) ? '1
		: acc_q[63+GAIN_FRAC_BITS:GAIN_FRAC_BITS];

endmodule

[src/skof_div.sv]
// ----------------------------------------------------------------------------
// skof_div
// Bit-serial restoring divider: floor(num * 2^48 / den), saturated at the
// selected limit (gain one or the largest signed 64-bit value).
// ----------------------------------------------------------------------------
module skof_div (
	input  logic              clk,
	input  logic              arst_n,
	input  skof_pkg::div_req_t req,
	output logic              done,
	output logic [63:0]       result
);
	import skof_pkg::*;

	logic [63:0]             n_q, d_q, r_q, q_q;
	logic                    ovf_q, dz_q, lim_one_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q, done_q;

	logic [64:0] rs, diff;
	logic        ge;
	logic [63:0] lim;

	// One restoring step
	always_comb begin
		rs   = {r_q, n_q[63]};
		diff = rs - {1'b0, d_q};
		ge   = (rs >= {1'b0, d_q});
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_BITS'(1);
				if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in dividend bits, shift out quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q       <= req.num;
			d_q       <= req.den;
			r_q       <= '0;
			q_q       <= '0;
			ovf_q     <= 1'b0;
			dz_q      <= (req.den == 64'd0);
			lim_one_q <= req.lim_one;
		end else if (busy_q) begin
			n_q   <= {n_q[62:0], 1'b0};
			r_q   <= ge ? diff[63:0] : rs[63:0];
			q_q   <= {q_q[62:0], ge};
			ovf_q <= ovf_q | q_q[63];
		end
	end

	assign lim    = lim_one_q ? GAIN_ONE : INT64_MAX;
	assign done   = done_q;
	assign result = (dz_q || ovf_q || (q_q > lim)) ? lim : q_q;

endmodule

[src/scalar_kalman_offset_filter.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_offset_filter
// One-dimensional Kalman filter for clock offset samples in nanoseconds.
// ----------------------------------------------------------------------------
// A correction item, or the first sample after reset or a restart, goes
// straight to result delivery. A later sample takes two divisions on the
// shared bit-serial divider (112 quotient steps each, one for the gain A and
// one for the Kalman gain K) and five products on the shared multiplier
// (four 32x32 partial products each), then loads the result. The division
// for A is skipped when the previous measurement is zero, and the one for K
// when the measurement variance is zero. A restart item gives no result.
// The block takes one item at a time; the output register lets it return
// to idle while a result waits to be taken.
module scalar_kalman_offset_filter #(
	parameter int unsigned TIME_BITS     = 48,
	parameter int unsigned VAR_FRAC_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [skof_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [31:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         req_type,
	input  logic signed [TIME_BITS-1:0]        time_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [TIME_BITS-1:0]        result_value,
	output logic                               is_estimate
);
	import skof_pkg::*;

	localparam logic [63:0] TMAX_U = 64'hFFFF_FFFF_FFFF_FFFF >> (65 - TIME_BITS);
	localparam logic signed [63:0] TMAX = signed'(TMAX_U);
	localparam logic signed [63:0] TMIN = ~TMAX;
	localparam logic [63:0] P_INIT = ((64'd1 << VAR_FRAC_BITS) + 64'd5) / 64'd10;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIVA = 4'd1;
	localparam logic [3:0] S_MUL1 = 4'd2;
	localparam logic [3:0] S_MUL2 = 4'd3;
	localparam logic [3:0] S_MUL3 = 4'd4;
	localparam logic [3:0] S_DIVK = 4'd5;
	localparam logic [3:0] S_MUL4 = 4'd6;
	localparam logic [3:0] S_MUL5 = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	function automatic logic [63:0] mag(input logic signed [63:0] x);
		return x[63] ? (64'd0 - x) : x;
	endfunction

	function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
		if (neg)
			return m[63] ? signed'(INT64_MIN) : signed'(64'd0 - m);
		return m[63] ? signed'(INT64_MAX) : signed'(m);
	endfunction

	function automatic logic signed [63:0] clamp_t(input logic signed [63:0] x);
		if (x > TMAX) return TMAX;
		if (x < TMIN) return TMIN;
		return x;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? signed'(INT64_MIN) : signed'(INT64_MAX);
		return s;
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] d;
		d = a - b;
		if (a[63] != b[63] && d[63] != a[63])
			return a[63] ? signed'(INT64_MIN) : signed'(INT64_MAX);
		return d;
	endfunction

	logic [3:0]                  state_q;
	logic                        issued_q;
	logic [31:0]                 pnv_q, mnv_q;
	logic signed [TIME_BITS-1:0] est_q, prev_q, corr_q;
	logic [63:0]                 err_q;
	logic                        started_q;
	logic signed [63:0]          y_q, bx_q;
	logic                        a_neg_q;
	logic [63:0]                 am_q, tmp_q, bp_q, k_q;
	logic signed [TIME_BITS-1:0] res_q;
	logic                        res_est_q;
	logic                        out_valid_q;
	logic signed [TIME_BITS-1:0] result_value_q;
	logic                        is_estimate_q;

	mul_req_t    mul_req;
	div_req_t    div_req;
	logic        mul_done, div_done;
	logic [63:0] mul_res, div_res;

	logic               in_acc;
	logic signed [63:0] y_in, est64, prev64, corr64;
	logic [63:0]        vk, wk;
	logic signed [63:0] a_val, innov, est_new;
	logic [64:0]        den_sum;
	logic [63:0]        num_k, den_k, bp_new;
	logic               mul_state, div_state, out_free;

	// Widen and align operands
	always_comb begin
		y_in   = 64'(time_value);
		est64  = 64'(est_q);
		prev64 = 64'(prev_q);
		corr64 = 64'(corr_q);
		vk     = {32'd0, pnv_q} << (VAR_FRAC_BITS - 8);
		wk     = {32'd0, mnv_q} << (VAR_FRAC_BITS - 8);
		in_acc = in_valid && in_ready;
		out_free = !out_valid_q || out_ready;
	end

	// Gain A from the divider quotient
	always_comb begin
		if (corr64[63] != prev64[63])
			a_val = signed'(GAIN_ONE - div_res);
		else if (div_res > (INT64_MAX - GAIN_ONE))
			a_val = signed'(INT64_MAX);
		else
			a_val = signed'(GAIN_ONE + div_res);
	end

	// Predicted variance, Kalman gain operands, innovation and new estimate
	always_comb begin
		bp_new  = (mul_res > ~vk) ? '1 : (mul_res + vk);
		den_sum = {1'b0, bp_q} + {1'b0, wk};
		if (den_sum[64]) begin
			num_k = bp_q >> 1;
			den_k = (bp_q >> 1) + (wk >> 1) + {63'd0, bp_q[0] & wk[0]};
		end else begin
			num_k = bp_q;
			den_k = den_sum[63:0];
		end
		innov   = sat_sub(y_q, bx_q);
		est_new = clamp_t(sat_add(bx_q, from_mag(innov[63], mul_res)));
	end

	// Drive the shared units
	always_comb begin
		mul_state = (state_q == S_MUL1) || (state_q == S_MUL2) || (state_q == S_MUL3)
			|| (state_q == S_MUL4) || (state_q == S_MUL5);
		div_state = (state_q == S_DIVA) || (state_q == S_DIVK);
		mul_req.start = mul_state && !issued_q;
		case (state_q)
			S_MUL1: begin mul_req.a = err_q;      mul_req.b = am_q; end
			S_MUL2: begin mul_req.a = tmp_q;      mul_req.b = am_q; end
			S_MUL3: begin mul_req.a = mag(est64); mul_req.b = am_q; end
			S_MUL4: begin mul_req.a = mag(innov); mul_req.b = k_q;  end
			default: begin mul_req.a = k_q;       mul_req.b = wk;   end
		endcase
		div_req.start = div_state && !issued_q;
		if (state_q == S_DIVA) begin
			div_req.num     = mag(corr64);
			div_req.den     = mag(prev64);
			div_req.lim_one = 1'b0;
		end else begin
			div_req.num     = num_k;
			div_req.den     = den_k;
			div_req.lim_one = 1'b1;
		end
	end

	skof_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.result (mul_res)
	);

	skof_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.result (div_res)
	);

	// Sequencer, filter state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			pnv_q       <= 32'd230400;
			mnv_q       <= 32'd25600;
			est_q       <= '0;
			err_q       <= '0;
			prev_q      <= TIME_BITS'(1);
			corr_q      <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROCESS_NOISE: pnv_q <= cfg_data;
					REG_MEAS_NOISE:    mnv_q <= cfg_data;
					default: ;
				endcase
			end
			// Drop the taken result unless a new one is loaded
			if (out_valid_q && out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			if (mul_req.start || div_req.start)
				issued_q <= 1'b1;
			else if (mul_done || div_done)
				issued_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (req_type)
							REQ_SAMPLE: begin
								if (!started_q) begin
									est_q     <= time_value;
									err_q     <= P_INIT;
									prev_q    <= time_value;
									started_q <= 1'b1;
									state_q   <= S_DONE;
								end else if (prev64 == 64'sd0) begin
									state_q <= S_MUL1;
								end else begin
									state_q <= S_DIVA;
								end
							end
							REQ_CORR: begin
								corr_q  <= time_value;
								state_q <= S_DONE;
							end
							REQ_RESTART: started_q <= 1'b0;
							default: ;
						endcase
					end
				end
				S_DIVA: if (div_done) state_q <= S_MUL1;
				S_MUL1: if (mul_done) state_q <= S_MUL2;
				S_MUL2: if (mul_done) state_q <= S_MUL3;
				S_MUL3: begin
					if (mul_done)
						state_q <= (wk == 64'd0) ? S_MUL4 : S_DIVK;
				end
				S_DIVK: if (div_done) state_q <= S_MUL4;
				S_MUL4: begin
					if (mul_done) begin
						est_q   <= TIME_BITS'(est_new);
						state_q <= S_MUL5;
					end
				end
				S_MUL5: begin
					if (mul_done) begin
						err_q     <= mul_res;
						prev_q    <= TIME_BITS'(y_q);
						started_q <= 1'b1;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and the result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					y_q       <= y_in;
					res_q     <= time_value;
					res_est_q <= (req_type == REQ_SAMPLE);
					a_neg_q   <= 1'b0;
					am_q      <= GAIN_ONE;
				end
			end
			S_DIVA: begin
				if (div_done) begin
					a_neg_q <= a_val[63];
					am_q    <= mag(a_val);
				end
			end
			S_MUL1: if (mul_done) tmp_q <= mul_res;
			S_MUL2: if (mul_done) bp_q <= bp_new;
			S_MUL3: begin
				if (mul_done) begin
					bx_q <= clamp_t(from_mag(est64[63] ^ a_neg_q, mul_res));
					k_q  <= GAIN_ONE;
				end
			end
			S_DIVK: if (div_done) k_q <= div_res;
			S_MUL5: if (mul_done) res_q <= est_q;
			S_DONE: begin
				if (out_free) begin
					result_value_q <= res_q;
					is_estimate_q  <= res_est_q;
				end
			end
			default: ;
		endcase
	end

	assign cfg_ready    = 1'b1;
	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign is_estimate  = is_estimate_q;

	// The two shared units never start together
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && div_req.start))
		else $error("multiplier and divider started together");

	// A correction transaction goes straight to result delivery
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req_type == REQ_CORR) |=> (state_q == S_DONE))
		else $error("correction did not go to result delivery");

	// Kalman gain never exceeds one when it is applied
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL4) |-> (k_q <= GAIN_ONE))
		else $error("Kalman gain above one");

	// A unit completion is only seen after a request was issued
	assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_done) |-> issued_q)
		else $error("unit completion without a request");

endmodule

[tb/sv/scalar_kalman_offset_filter_tb.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_offset_filter_tb
// Self-checking bench for the scalar Kalman offset filter: an in-bench
// fixed-point predictor tracks the filter state per accepted transaction and
// a scoreboard compares every result, while bursty input and stalling output
// sweep several noise variance settings.
// ----------------------------------------------------------------------------
module scalar_kalman_offset_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import skof_pkg::*;

	localparam longint TMAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint TMIN = -TMAX - 1;
	localparam int     SETTLE_CYCLES = 400;
	localparam int     CYCLE_LIMIT = 3000000;

	// Predict filter outputs and hold the results still owed by the block
	class offset_scoreboard;
		bit [31:0]  proc_var = 32'd230400;
		bit [31:0]  meas_var = 32'd25600;
		longint     est;
		bit [63:0]  err_var;
		longint     prev_meas;
		longint     corr;
		bit         started;
		longint     owed_value[$];
		bit         owed_flag[$];
		int         errors;

		function void clear_state();
			est = 0;
			err_var = 0;
			prev_meas = 1;
			corr = 0;
			started = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, bit [31:0] data);
			if (idx == REG_PROCESS_NOISE)
				proc_var = data;
			else
				meas_var = data;
		endfunction

		// (a * b) >> 48, saturated at all ones
		function bit [63:0] mul_q48(bit [63:0] a, bit [63:0] b);
			bit [127:0] p;
			p = {64'b0, a} * {64'b0, b};
			if (p[127:112] != 0)
				return '1;
			return p[111:48];
		endfunction

		// floor(n * 2^48 / d), saturated at lim
		function bit [63:0] div_q48(bit [63:0] n, bit [63:0] d, bit [63:0] lim);
			bit [127:0] q;
			if (d == 0)
				return lim;
			q = ({64'b0, n} << 48) / {64'b0, d};
			if (q > {64'b0, lim})
				return lim;
			return q[63:0];
		endfunction

		function bit [63:0] abs64(longint x);
			return (x < 0) ? -x : x;
		endfunction

		function longint signed_of(bit neg, bit [63:0] m);
			if (neg)
				return (m >= INT64_MIN) ? longint'(INT64_MIN) : -longint'(m);
			return (m > INT64_MAX) ? longint'(INT64_MAX) : longint'(m);
		endfunction

		function longint clamp_time(longint x);
			if (x > TMAX)
				return TMAX;
			if (x < TMIN)
				return TMIN;
			return x;
		endfunction

		function void filter_sample(longint y);
			longint    a, bx, innov, step;
			bit [63:0] m, am, vk, wk, bp, k, num, den;
			if (!started) begin
				est = y;
				err_var = 64'd429496730;
			end else begin
				// gain from the correction relative to the last measurement
				if (prev_meas == 0) begin
					a = longint'(GAIN_ONE);
				end else begin
					m = div_q48(abs64(corr), abs64(prev_meas), INT64_MAX);
					if ((corr < 0) != (prev_meas < 0))
						a = longint'(GAIN_ONE) - longint'(m);
					else if (m > INT64_MAX - GAIN_ONE)
						a = longint'(INT64_MAX);
					else
						a = longint'(GAIN_ONE + m);
				end
				am = abs64(a);
				vk = {32'b0, proc_var} << 24;
				wk = {32'b0, meas_var} << 24;
				// predict
				bp = mul_q48(mul_q48(err_var, am), am);
				bp = (bp > ~vk) ? '1 : bp + vk;
				bx = clamp_time(signed_of((est < 0) != (a < 0), mul_q48(abs64(est), am)));
				// Kalman gain, halving both terms when the sum overflows
				if (wk == 0) begin
					k = GAIN_ONE;
				end else begin
					num = bp;
					den = bp + wk;
					if (den < bp) begin
						num = bp >> 1;
						den = (bp >> 1) + (wk >> 1) + (bp & wk & 64'd1);
					end
					k = div_q48(num, den, GAIN_ONE);
				end
				// update
				innov = y - bx;
				step = signed_of(innov < 0, mul_q48(abs64(innov), k));
				est = clamp_time(bx + step);
				err_var = mul_q48(k, wk);
			end
			prev_meas = y;
			started = 1;
		endfunction

		function void note_input(logic [1:0] req, longint v);
			case (req)
				REQ_SAMPLE: begin
					filter_sample(v);
					owed_value.push_back(est);
					owed_flag.push_back(1'b1);
				end
				REQ_CORR: begin
					corr = v;
					owed_value.push_back(v);
					owed_flag.push_back(1'b0);
				end
				REQ_RESTART: begin
					started = 0;
				end
				default: ;
			endcase
		endfunction

		function void check_result(longint v, bit flag);
			longint exp_v;
			bit     exp_f;
			if (owed_value.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result value=%0d is_estimate=%0b", v, flag);
				return;
			end
			exp_v = owed_value.pop_front();
			exp_f = owed_flag.pop_front();
			if (exp_v != v || exp_f != flag) begin
				errors++;
				if (errors <= 10)
					$display("result mismatch: expected value=%0d is_estimate=%0b, got value=%0d is_estimate=%0b",
						exp_v, exp_f, v, flag);
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [31:0]              cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               req_type;
	logic signed [47:0]       time_value;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [47:0]       result_value;
	logic                     is_estimate;

	offset_scoreboard sb = new;
	int unsigned      cycle_count;
	int unsigned      stall_phase;

	scalar_kalman_offset_filter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.time_value   (time_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.is_estimate  (is_estimate)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Stall the output side: always ready, random, then a fixed 3-of-7 pattern
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		case ((stall_phase / 700) % 3)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 0);
			default: out_ready <= ((stall_phase % 7) < 3);
		endcase
	end

	// Check every result transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(longint'(result_value), is_estimate);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, bit [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(logic [1:0] req, longint v);
		in_valid <= 1'b1;
		req_type <= req;
		time_value <= v[47:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(req, v);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold input until every owed result has come, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_value.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic longint full_time();
		bit [47:0] r;
		r = 48'({$urandom(), $urandom()});
		return longint'($signed(r));
	endfunction

	function automatic longint near_time(longint base, int spread);
		return base + $urandom_range(0, 2 * spread) - spread;
	endfunction

	initial begin
		int     burst_left;
		int     n_items;
		int     n_samples;
		longint offset;
		bit [31:0] pv, mv;

		cycle_count = 0;
		stall_phase = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PROCESS_NOISE;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_SAMPLE;
		time_value = '0;
		out_ready = 1'b0;
		sb.clear_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero previous measurement, overflowing variance
		send_item(REQ_SAMPLE, 0);
		send_item(REQ_SAMPLE, 1000);
		send_item(REQ_CORR, 50);
		send_item(REQ_SAMPLE, 1020);
		send_item(REQ_SAMPLE, TMAX);
		send_item(REQ_SAMPLE, TMIN);
		send_item(REQ_CORR, TMIN);
		send_item(REQ_SAMPLE, -5);
		send_item(REQ_CORR, TMAX);
		send_item(REQ_SAMPLE, 0);
		send_item(REQ_SAMPLE, 7);
		send_item(2'd3, 12345);
		send_item(REQ_RESTART, 0);
		send_item(REQ_SAMPLE, 100);
		send_item(REQ_CORR, -3);
		send_item(REQ_SAMPLE, 200);
		drain();
		write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
		write_reg(REG_MEAS_NOISE, 32'd0);
		send_item(REQ_SAMPLE, 1);
		send_item(REQ_CORR, TMAX);
		send_item(REQ_SAMPLE, 1);
		send_item(REQ_SAMPLE, -TMAX);
		drain();
		write_reg(REG_MEAS_NOISE, 32'hFFFF_FFFF);
		send_item(REQ_SAMPLE, 1);
		send_item(REQ_SAMPLE, 3);
		send_item(REQ_SAMPLE, -1);
		drain();

		// Random phases, each under its own noise setting
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin pv = 32'd230400; mv = 32'd25600; end
				1: begin pv = 32'd0; mv = 32'd0; end
				2: begin pv = 32'hFFFF_FFFF; mv = 32'hFFFF_FFFF; end
				3: begin pv = 32'd0; mv = 32'hFFFF_FFFF; end
				4: begin pv = 32'hFFFF_FFFF; mv = 32'd0; end
				default: begin pv = $urandom(); mv = $urandom_range(0, 1 << 20); end
			endcase
			write_reg(REG_PROCESS_NOISE, pv);
			write_reg(REG_MEAS_NOISE, mv);
			n_items = 0;
			burst_left = 0;
			while (n_items < 150) begin
				offset = ($urandom_range(0, 9) == 0) ? full_time() / 4 :
					near_time(0, 100000);
				if ($urandom_range(0, 2) == 0)
					send_item(REQ_RESTART, 0);
				else
					send_item(REQ_CORR, near_time(0, 500));
				n_items++;
				n_samples = $urandom_range(3, 12);
				for (int s = 0; s < n_samples; s++) begin
					// Mostly well-formed samples, sometimes noise
					case ($urandom_range(0, 19))
						0: send_item(REQ_SAMPLE, full_time());
						1: send_item(2'd3, full_time());
						2: send_item(REQ_CORR, full_time());
						3: send_item(REQ_SAMPLE, 0);
						default: send_item(REQ_SAMPLE, near_time(offset, 2000));
					endcase
					n_items++;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 20);
						idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400));
					end else begin
						burst_left--;
					end
				end
			end
			drain();
		end

		if (sb.errors == 0 && sb.owed_value.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
